/* rtl/deq_pkg.sv */
// ============================================================================
// deq_pkg
// Shared types and constants for the double-ended queue core: operation
// codes, status codes, store geometry and the packed result record.
// ============================================================================
package deq_pkg;

    // Store geometry
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Field widths of one transfer
    localparam int OP_W     = 3;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;

    // Stream bus widths (fields packed from bit 0, tdata padded to whole bytes)
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = STATUS_W;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    // Result record carried from the decode stage to the output stage
    typedef struct packed {
        logic [CNT_W-1:0]    occupancy;
        logic [STATUS_W-1:0] status;
        logic                read_ok;
    } result_t;

endpackage

/* rtl/double_ended_queue_core.sv */
// ============================================================================
// double_ended_queue_core
// Fixed-capacity double-ended queue of signed words held in a ring store.
// ============================================================================
// The core takes one operation per cycle (push front, push back, pop front,
// pop back, read at a position counted from the front) and returns exactly
// one result for each: read data, occupancy after the operation and a status
// (ok, empty, full, out of range). Front pointer and element count update in
// the cycle the operation is accepted, and pushes write the ring store in
// that same cycle, so a following operation sees the new state with
// no stall. A read issues its address on acceptance; the store's registered
// read port captures the word beside the decode-stage record, and the output
// register merges the two for the master side. Sustained rate is one
// operation per clock while the master side keeps taking results; a stalled
// result is held in the output register while one more operation is taken.
// ============================================================================
module double_ended_queue_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [deq_pkg::S_TDATA_W-1:0]   s_tdata,  // value[31:0], position[37:32], pad
    input  logic [deq_pkg::S_TUSER_W-1:0]   s_tuser,  // op[2:0]
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [deq_pkg::M_TDATA_W-1:0]   m_tdata,  // read_data[31:0], occupancy[38:32], pad
    output logic [deq_pkg::M_TUSER_W-1:0]   m_tuser   // status[1:0]
);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic [deq_pkg::DATA_WIDTH-1:0] store_mem [deq_pkg::DEPTH];

    logic [deq_pkg::ADDR_W-1:0]     front_reg;
    logic [deq_pkg::ADDR_W-1:0]     front_next;
    logic [deq_pkg::CNT_W-1:0]      count_reg;
    logic [deq_pkg::CNT_W-1:0]      count_next;

    logic [deq_pkg::OP_W-1:0]       op;
    logic [deq_pkg::DATA_WIDTH-1:0] value;
    logic [deq_pkg::POS_W-1:0]      position;

    logic                           is_full;
    logic                           is_empty;
    logic                           wr_en;
    logic [deq_pkg::ADDR_W-1:0]     wr_addr;
    logic                           rd_en;
    logic [deq_pkg::ADDR_W-1:0]     rd_addr;
    logic [deq_pkg::STATUS_W-1:0]   status;
    logic [deq_pkg::DATA_WIDTH-1:0] rd_data_reg;

    deq_pkg::result_t               s1_res_reg;
    logic                           s1_valid_reg;
    logic                           s1_advance;
    logic                           s_fire;

    logic                           out_valid_reg;
    logic [deq_pkg::DATA_WIDTH-1:0] out_data_reg;
    logic [deq_pkg::CNT_W-1:0]      out_occ_reg;
    logic [deq_pkg::STATUS_W-1:0]   out_status_reg;

    // ------------------------------------------------------------------
    // Unpack the input transfer
    // ------------------------------------------------------------------
    assign op       = s_tuser;
    assign value    = s_tdata[deq_pkg::DATA_WIDTH-1:0];
    assign position = s_tdata[deq_pkg::DATA_WIDTH +: deq_pkg::POS_W];

    // ------------------------------------------------------------------
    // Handshake: take an operation when the decode stage is free or moves on
    // ------------------------------------------------------------------
    assign s1_advance = !out_valid_reg || m_tready;
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_fire     = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Decode the operation against the current pointer and count
    // ------------------------------------------------------------------
    assign is_full  = (count_reg == deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign is_empty = (count_reg == '0);

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = front_reg;
        rd_en      = 1'b0;
        rd_addr    = front_reg + deq_pkg::ADDR_W'(position);
        status     = deq_pkg::ST_OK;
        unique case (op)
            deq_pkg::OP_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status = deq_pkg::ST_FULL;
                end
                else
                begin
                    front_next = front_reg - 1'b1;
                    wr_en      = 1'b1;
                    wr_addr    = front_reg - 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            deq_pkg::OP_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status = deq_pkg::ST_FULL;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = front_reg + count_reg[deq_pkg::ADDR_W-1:0];
                    count_next = count_reg + 1'b1;
                end
            end
            deq_pkg::OP_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    front_next = front_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            deq_pkg::OP_POP_BACK:
            begin
                if (is_empty)
                begin
                    status = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            deq_pkg::OP_READ:
            begin
                if (is_empty)
                begin
                    status = deq_pkg::ST_EMPTY;
                end
                else if (deq_pkg::CNT_W'(position) >= count_reg)
                begin
                    status = deq_pkg::ST_RANGE;
                end
                else
                begin
                    rd_en = 1'b1;
                end
            end
            default:
            begin
                status = deq_pkg::ST_OK;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Advance pointer and count on each accepted transfer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (s_fire)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // Ring store: one write and one registered read per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s_fire && wr_en)
        begin
            store_mem[wr_addr] <= value;
        end
        if (s_fire && rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Decode stage: hold the result record while the read completes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_res_reg.occupancy <= count_next;
            s1_res_reg.status    <= status;
            s1_res_reg.read_ok   <= rd_en;
        end
    end

    // ------------------------------------------------------------------
    // Output register: merge read data, drop it for non-read results
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_valid_reg)
        begin
            out_data_reg   <= s1_res_reg.read_ok ? rd_data_reg : '0;
            out_occ_reg    <= s1_res_reg.occupancy;
            out_status_reg <= s1_res_reg.status;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(deq_pkg::M_TDATA_W - deq_pkg::DATA_WIDTH - deq_pkg::CNT_W){1'b0}},
                       out_occ_reg, out_data_reg};
    assign m_tuser  = out_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= deq_pkg::CNT_W'(deq_pkg::DEPTH))
        else $error("element count exceeds store depth");

    a_full_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && is_full && (op == deq_pkg::OP_PUSH_FRONT || op == deq_pkg::OP_PUSH_BACK))
        |=> $stable(count_reg) && $stable(front_reg))
        else $error("refused push changed queue state");

    a_fire_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> s1_valid_reg)
        else $error("accepted transfer did not reach decode stage");

    a_error_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_status_reg != deq_pkg::ST_OK) |-> (out_data_reg == '0))
        else $error("refused operation returned nonzero read data");

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && rd_en) |-> (deq_pkg::CNT_W'(position) < count_reg))
        else $error("store read issued beyond occupancy");

endmodule

/* test/deq_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// deq_checker
// Watches both stream channels of the double-ended queue core, keeps its own
// model of the ring store, front index and fill level, and compares every
// result transfer with the oldest predicted result.
// ============================================================================
module deq_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [deq_pkg::S_TDATA_W-1:0] s_tdata,   // value[31:0], position[37:32], pad
    input  logic [deq_pkg::S_TUSER_W-1:0] s_tuser,   // op[2:0]
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [deq_pkg::M_TDATA_W-1:0] m_tdata,   // read_data[31:0], occupancy[38:32], pad
    input  logic [deq_pkg::M_TUSER_W-1:0] m_tuser,   // status[1:0]
    output int                            mismatch_count,
    output int                            pending_count
);

    typedef struct packed {
        logic [deq_pkg::DATA_WIDTH-1:0] read_data;
        logic [deq_pkg::CNT_W-1:0]      occupancy;
        logic [deq_pkg::STATUS_W-1:0]   status;
    } deq_result_t;

    logic [deq_pkg::DATA_WIDTH-1:0] ring_words [deq_pkg::DEPTH];
    logic [deq_pkg::ADDR_W-1:0]     head_idx;
    logic [deq_pkg::CNT_W-1:0]      fill_level;
    deq_result_t                    queued_results [$];

    // Apply one operation to the model and return the result it should give
    task automatic apply_deq_op(
        input  logic [deq_pkg::OP_W-1:0]       op,
        input  logic [deq_pkg::DATA_WIDTH-1:0] value,
        input  logic [deq_pkg::POS_W-1:0]      position,
        output deq_result_t                    res
    );
        logic [deq_pkg::ADDR_W-1:0] slot;
        res = '0;
        res.status = deq_pkg::ST_OK;
        case (op)
            deq_pkg::OP_PUSH_FRONT:
            begin
                if (fill_level >= deq_pkg::CNT_W'(deq_pkg::DEPTH))
                    res.status = deq_pkg::ST_FULL;
                else
                begin
                    head_idx = head_idx - 1'b1;
                    ring_words[head_idx] = value;
                    fill_level = fill_level + 1'b1;
                end
            end
            deq_pkg::OP_PUSH_BACK:
            begin
                if (fill_level >= deq_pkg::CNT_W'(deq_pkg::DEPTH))
                    res.status = deq_pkg::ST_FULL;
                else
                begin
                    slot = head_idx + fill_level[deq_pkg::ADDR_W-1:0];
                    ring_words[slot] = value;
                    fill_level = fill_level + 1'b1;
                end
            end
            deq_pkg::OP_POP_FRONT:
            begin
                if (fill_level == '0)
                    res.status = deq_pkg::ST_EMPTY;
                else
                begin
                    head_idx = head_idx + 1'b1;
                    fill_level = fill_level - 1'b1;
                end
            end
            deq_pkg::OP_POP_BACK:
            begin
                if (fill_level == '0)
                    res.status = deq_pkg::ST_EMPTY;
                else
                    fill_level = fill_level - 1'b1;
            end
            deq_pkg::OP_READ:
            begin
                if (fill_level == '0)
                    res.status = deq_pkg::ST_EMPTY;
                else if (deq_pkg::CNT_W'(position) >= fill_level)
                    res.status = deq_pkg::ST_RANGE;
                else
                begin
                    slot = head_idx + position;
                    res.read_data = ring_words[slot];
                end
            end
            default:
            begin
                // spare op codes leave the state alone
            end
        endcase
        res.occupancy = fill_level;
    endtask

    // Predict on input transfers, compare on result transfers
    always @(posedge clk or negedge rst_n)
    begin
        deq_result_t predicted;
        deq_result_t oldest;
        if (!rst_n)
        begin
            head_idx = '0;
            fill_level = '0;
            queued_results.delete();
            mismatch_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_deq_op(s_tuser, s_tdata[31:0], s_tdata[37:32], predicted);
                queued_results.insert(queued_results.size(), predicted);
            end
            if (m_tvalid && m_tready)
            begin
                if (queued_results.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%0t: result with nothing pending: data=%h occ=%0d st=%0d",
                                 $realtime, m_tdata[31:0], m_tdata[38:32], m_tuser);
                    mismatch_count++;
                end
                else
                begin
                    oldest = queued_results[0];
                    queued_results.delete(0);
                    if (m_tdata[31:0] !== oldest.read_data
                        || m_tdata[38:32] !== oldest.occupancy
                        || m_tuser !== oldest.status)
                    begin
                        if (mismatch_count < 10)
                            $display({"%0t: mismatch: data exp %h got %h, ",
                                      "occ exp %0d got %0d, st exp %0d got %0d"},
                                     $realtime, oldest.read_data, m_tdata[31:0],
                                     oldest.occupancy, m_tdata[38:32],
                                     oldest.status, m_tuser);
                        mismatch_count++;
                    end
                end
            end
            pending_count = queued_results.size();
        end
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Stimulus and verdict for the double-ended queue core.
// ============================================================================
// A short directed sequence covers empty pops and reads, spare op codes,
// extreme values and out-of-range reads; then random operations run in fill,
// drain and mixed stretches so the store hits both full and empty. Four
// phases vary the sender gaps and receiver back-pressure. Checking is done
// by deq_checker, which sits beside the core.
// ============================================================================
module tb_top;

    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 356;
    localparam int DRAIN_CYCLES = 8;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    logic                          clk;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [deq_pkg::S_TDATA_W-1:0] s_tdata;    // value[31:0], position[37:32], pad
    logic [deq_pkg::S_TUSER_W-1:0] s_tuser;    // op[2:0]
    logic                          m_tvalid;
    logic                          m_tready;
    logic [deq_pkg::M_TDATA_W-1:0] m_tdata;    // read_data[31:0], occupancy[38:32], pad
    logic [deq_pkg::M_TUSER_W-1:0] m_tuser;    // status[1:0]

    int mismatch_count;
    int pending_count;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    double_ended_queue_core i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    deq_checker i_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: abort when nothing transfers for too long
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Present one operation, hold it until taken, then maybe idle
    task automatic send_op(
        input logic [deq_pkg::OP_W-1:0]       op,
        input logic [deq_pkg::DATA_WIDTH-1:0] value,
        input logic [deq_pkg::POS_W-1:0]      position
    );
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, position, value};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Draw one random operation biased by the current stretch mode
    task automatic send_random_op(input int mode);
        int                             roll;
        int                             push_cut;
        int                             pop_cut;
        logic [deq_pkg::OP_W-1:0]       op;
        logic [deq_pkg::DATA_WIDTH-1:0] value;
        logic [deq_pkg::POS_W-1:0]      position;
        roll = $urandom_range(99);
        case (mode)
            MODE_FILL:  begin push_cut = 70; pop_cut = 80; end
            MODE_DRAIN: begin push_cut = 15; pop_cut = 75; end
            default:    begin push_cut = 40; pop_cut = 75; end
        endcase
        if (roll < push_cut)
            op = $urandom_range(1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
        else if (roll < pop_cut)
            op = $urandom_range(1) ? deq_pkg::OP_POP_BACK : deq_pkg::OP_POP_FRONT;
        else if (roll < 96)
            op = deq_pkg::OP_READ;
        else
            op = deq_pkg::OP_READ + deq_pkg::OP_W'($urandom_range(1, 3));
        case ($urandom_range(9))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            2:       value = $urandom_range(1) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            default: value = $urandom;
        endcase
        position = $urandom_range(1) ? deq_pkg::POS_W'($urandom_range(63))
                                     : deq_pkg::POS_W'($urandom_range(15));
        send_op(op, value, position);
    endtask

    // Stimulus and verdict
    initial
    begin
        int phase;
        int items_left;
        int stretch;
        int mode;
        rst_n          <= 1'b0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= deq_pkg::OP_PUSH_FRONT;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty store, spare codes, extremes, range edges
        send_op(deq_pkg::OP_POP_FRONT, 32'h0, 6'd0);
        send_op(deq_pkg::OP_POP_BACK, 32'h0, 6'd0);
        send_op(deq_pkg::OP_READ, 32'h0, 6'd0);
        send_op(deq_pkg::OP_READ, 32'hFFFF_FFFF, 6'd63);
        send_op(deq_pkg::OP_READ + 3'd1, 32'h1234_5678, 6'd0);
        send_op(deq_pkg::OP_READ + 3'd2, 32'h0, 6'd0);
        send_op(deq_pkg::OP_READ + 3'd3, 32'h0, 6'd0);
        send_op(deq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF, 6'd0);
        send_op(deq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 6'd63);
        send_op(deq_pkg::OP_PUSH_BACK, 32'h0000_0000, 6'd0);
        send_op(deq_pkg::OP_PUSH_FRONT, 32'hFFFF_FFFF, 6'd0);
        send_op(deq_pkg::OP_READ, 32'h0, 6'd0);
        send_op(deq_pkg::OP_READ, 32'h0, 6'd3);
        send_op(deq_pkg::OP_READ, 32'h0, 6'd4);
        send_op(deq_pkg::OP_READ, 32'h0, 6'd63);
        send_op(deq_pkg::OP_READ + 3'd3, 32'hFFFF_FFFF, 6'd63);
        send_op(deq_pkg::OP_PUSH_BACK, 32'hAAAA_AAAA, 6'd0);
        send_op(deq_pkg::OP_READ, 32'h0, 6'd4);
        send_op(deq_pkg::OP_POP_BACK, 32'h0, 6'd0);
        send_op(deq_pkg::OP_POP_FRONT, 32'h0, 6'd0);
        send_op(deq_pkg::OP_READ, 32'h0, 6'd0);
        send_op(deq_pkg::OP_READ, 32'h0, 6'd2);
        send_op(deq_pkg::OP_READ, 32'h0, 6'd3);

        // Random: no idling, sender gaps, receiver stalls, light both
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
            endcase
            items_left = PHASE_ITEMS;
            while (items_left > 0)
            begin
                mode = $urandom_range(MODE_MIXED);
                stretch = $urandom_range(60, 160);
                while (stretch > 0 && items_left > 0)
                begin
                    send_random_op(mode);
                    stretch--;
                    items_left--;
                end
            end
        end
        s_tvalid <= 1'b0;

        // Wait for the last results away from the sampling edge, then settle
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && pending_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/deq_pkg.sv
rtl/double_ended_queue_core.sv
test/deq_checker.sv
test/tb_top.sv
